>>> sv/pbmc_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and status codes of the pointer bounds metadata checker
package pbmc_pkg;

  localparam int ENTRIES    = 4;
  localparam int ADDR_BITS  = 48;
  localparam int ELEM_BYTES = 4;

  localparam int FIELD_W  = 48;
  localparam int OFFSET_W = 16;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  // pointer plus scaled offset never wraps at this width
  localparam int SUM_W    = FIELD_W + OFFSET_W + 5;

  localparam logic [FIELD_W-1:0] ADDR_MASK = {FIELD_W{1'b1}} >> (FIELD_W - ADDR_BITS);

  localparam int IN_DATA_W  = 4 * FIELD_W + OFFSET_W;
  localparam int OUT_DATA_W = 2 * FIELD_W;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_ALLOWED   = 3'd2,
    ST_VIOLATION = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // one item as it walks the row of cells
  typedef struct packed {
    logic               vld;
    op_t                op;
    logic               hit;
    logic               ok;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] ptr;
    logic [SUM_W-1:0]   addr;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] bound;
  } probe_t;

endpackage

>>> sv/pointer_bounds_metadata_checker.sv
`timescale 1ns / 1ps
// Pointer bounds metadata checker. Holds up to ENTRIES records of key, base and bound.
// in_ channel: in_tuser is the op (store or check), in_tdata carries key, base, bound,
// pointer and offset. A store appends a record in insertion order, or reports the table
// full. A check finds the oldest record with that key and allows the access when
// pointer >= base and pointer + offset * ELEM_BYTES < bound, compared at full width.
// out_ channel: out_tuser is the status, out_tdata the matched base and bound (zero
// unless a check found its key). One result per transfer in.
// The item walks a row of ENTRIES cells, one cell per cycle while the output register is
// not stalled, each cell comparing its own record; the item is registered in p0_r, in each
// cell and then in the output register. One item is in flight at a time, so a new transfer
// is taken only after the last one has left the row. in_tready is high whenever no item is
// in flight, also while a result waits in the output register.
// When the receiver stalls, the result holds in the output register and the row
// freezes behind it. Reset empties the table and the row; no clearing pass is needed.
module pointer_bounds_metadata_checker
  import pbmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key, base, bound, pointer, offset
  input  logic                  in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // entry_base, entry_bound
  output logic [2:0]            out_tuser   // status
);

  probe_t                chain [ENTRIES+1];
  probe_t                p0_r;
  probe_t                last;
  logic                  busy_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  status_t               out_status_r;
  status_t               status_nxt;
  logic [CNT_W-1:0]      count_r;
  logic [ENTRIES-1:0]    live;
  logic                  en;
  logic                  accept;
  logic                  done;
  logic [FIELD_W-1:0]    in_ptr;
  logic [OFFSET_W-1:0]   in_off;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign en        = !out_valid_r || out_tready;
  assign last      = chain[ENTRIES];
  assign done      = en && last.vld;

  assign in_ptr = in_tdata[4*FIELD_W-1:3*FIELD_W] & ADDR_MASK;
  assign in_off = in_tdata[4*FIELD_W+OFFSET_W-1:4*FIELD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r.vld <= 1'b0;
    end else if (accept) begin
      p0_r.vld   <= 1'b1;
      p0_r.op    <= op_t'(in_tuser);
      p0_r.hit   <= 1'b0;
      p0_r.ok    <= 1'b0;
      p0_r.key   <= in_tdata[FIELD_W-1:0] & ADDR_MASK;
      p0_r.base  <= in_tdata[2*FIELD_W-1:FIELD_W] & ADDR_MASK;
      p0_r.bound <= in_tdata[3*FIELD_W-1:2*FIELD_W] & ADDR_MASK;
      p0_r.ptr   <= in_ptr;
      p0_r.addr  <= SUM_W'(in_ptr) + SUM_W'(in_off) * SUM_W'(ELEM_BYTES);
    end else if (en) begin
      p0_r.vld <= 1'b0;
    end
  end

  assign chain[0] = p0_r;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign live[i] = CNT_W'(i) < count_r;
    pbmc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .live    (live[i]),
      .probe_i (chain[i]),
      .probe_o (chain[i+1])
    );
  end

  always_comb begin
    if (last.op == OP_STORE) begin
      status_nxt = last.hit ? ST_STORED : ST_FULL;
    end else if (!last.hit) begin
      status_nxt = ST_NOT_FOUND;
    end else begin
      status_nxt = last.ok ? ST_ALLOWED : ST_VIOLATION;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (done && (last.op == OP_STORE) && last.hit) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r <= status_nxt;
      if ((last.op == OP_CHECK) && last.hit) begin
        out_data_r <= {last.bound, last.base};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

>>> sv/pbmc_cell.sv
`timescale 1ns / 1ps
// one table entry: holds a record, takes a store or matches a check as the item passes
module pbmc_cell
  import pbmc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   live,
  input  probe_t probe_i,
  output probe_t probe_o
);

  logic [FIELD_W-1:0] key_r;
  logic [FIELD_W-1:0] base_r;
  logic [FIELD_W-1:0] bound_r;
  probe_t             probe_r;
  probe_t             probe_nxt;
  logic               wr;
  logic               match;

  // first free entry takes the store
  assign wr    = probe_i.vld && (probe_i.op == OP_STORE) && !probe_i.hit && !live;
  assign match = probe_i.vld && (probe_i.op == OP_CHECK) && !probe_i.hit && live
                 && (key_r == probe_i.key);

  always_comb begin
    probe_nxt = probe_i;
    if (wr) begin
      probe_nxt.hit = 1'b1;
    end
    if (match) begin
      probe_nxt.hit   = 1'b1;
      probe_nxt.base  = base_r;
      probe_nxt.bound = bound_r;
      probe_nxt.ok    = (probe_i.ptr >= base_r) && (probe_i.addr < SUM_W'(bound_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr) begin
      key_r   <= probe_i.key;
      base_r  <= probe_i.base;
      bound_r <= probe_i.bound;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else if (en) begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_o = probe_r;

endmodule

>>> sv/pbmc_checker.sv
`timescale 1ns / 1ps
// port-level checks for the pointer bounds metadata checker, bound to the top level
module pbmc_checker
  import pbmc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]            out_tuser
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one item in flight: no second transfer straight after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_STORED) || (out_tuser == ST_FULL)
      || (out_tuser == ST_ALLOWED) || (out_tuser == ST_VIOLATION)
      || (out_tuser == ST_NOT_FOUND))
    else $error("status out of range");

  // only a check that found its key reports a record
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_STORED) || (out_tuser == ST_FULL)
      || (out_tuser == ST_NOT_FOUND)) |-> out_tdata == '0)
    else $error("record data on a result without a match");

  // an input transfer cannot produce a result in the very next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

endmodule

bind pointer_bounds_metadata_checker pbmc_checker u_pbmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
